/* design/tds_pkg.sv */
// shared types and constants for the trajectory derivative stream unit
// no dependencies

package tds_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [19:0] speed;
        logic signed [31:0] rel_time;
        logic               last_point;
    } tds_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [15:0] out_heading;
        logic signed [19:0] out_speed;
        logic signed [31:0] out_time;
        logic        [31:0] arc_length;
        logic signed [31:0] accel;
        logic signed [31:0] jerk;
        logic signed [31:0] curvature;
        logic signed [31:0] curvature_rate;
        logic signed [31:0] curvature_accel;
        logic               end_of_run;
    } tds_out_t;

    localparam int WIN = 3;
    localparam logic signed [15:0] PI_Q12 = 16'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
    localparam logic signed [63:0] US_PER_S = 64'sd1000000;
    localparam logic signed [63:0] MM_PER_M = 64'sd1000;
    localparam logic signed [63:0] CURV_SCALE = 64'sd16000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // shared unit operations
    localparam logic [1:0] OP_SQRT = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;

    // update and emit steps
    localparam logic [3:0] S_SQX   = 4'd0;
    localparam logic [3:0] S_SQY   = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_ARC   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_CURV  = 4'd5;
    localparam logic [3:0] S_DK    = 4'd6;
    localparam logic [3:0] S_DKEND = 4'd7;
    localparam logic [3:0] S_JERK  = 4'd8;
    localparam logic [3:0] S_CACC  = 4'd9;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } tds_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tds_sts_t;

endpackage

/* design/tds_arith.sv */
// shared multi-cycle unit: rounded 64-bit square root or signed saturating divide
// depends on tds_pkg

module tds_arith
    import tds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tds_cmd_t           cmd,
    input  logic        [63:0] opa,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output tds_sts_t           sts,
    output logic        [63:0] res
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [1:0]  op_reg, op_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] r_reg, r_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic [1:0]  zsign_reg, zsign_next;
    logic [63:0] res_reg, res_next;

    logic [64:0] trial;
    logic [64:0] sq_rem;
    logic [63:0] sq_root;
    logic [63:0] qs;
    logic [63:0] root_fin;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        r_next     = r_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        zsign_next = zsign_reg;
        res_next   = res_reg;
        trial      = '0;
        sq_rem     = '0;
        sq_root    = '0;
        qs         = '0;
        root_fin   = '0;
        if (cmd.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = '0;
            if (cmd.op == OP_SQRT)
            begin
                a_next   = opa;
                r_next   = '0;
                rem_next = '0;
            end
            else
            begin
                neg_next   = num[63] ^ den[63];
                zero_next  = (den == 64'sd0);
                zsign_next = {num[63], num != 64'sd0};
                a_next     = num[63] ? 64'(-num) : 64'(num);
                d_next     = den[63] ? 64'(-den) : 64'(den);
                rem_next   = '0;
                q_next     = '0;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_SQRT)
            begin
                // one result bit per cycle, two radicand bits in
                sq_rem = {rem_reg[62:0], a_reg[63:62]};
                trial  = {r_reg[62:0], 2'b01};
                if (sq_rem >= trial)
                begin
                    rem_next = sq_rem - trial;
                    r_next   = {r_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = sq_rem;
                    r_next   = {r_reg[62:0], 1'b0};
                end
                a_next   = {a_reg[61:0], 2'b00};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    sq_root = r_next;
                    // remainder equals n - root^2; round up when it exceeds root
                    root_fin = (rem_next[63:0] > sq_root) ? sq_root + 64'd1 : sq_root;
                    res_next  = root_fin;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                sq_rem = {rem_reg[63:0], a_reg[63]};
                if (sq_rem >= {1'b0, d_reg})
                begin
                    rem_next = sq_rem - {1'b0, d_reg};
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = sq_rem;
                    q_next   = {q_reg[62:0], 1'b0};
                end
                a_next   = {a_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    qs = q_next;
                    if (zero_reg)
                        res_next = !zsign_reg[0] ? 64'd0 :
                                   (zsign_reg[1] ? 64'(signed'(S32_MIN))
                                                 : 64'(signed'(S32_MAX)));
                    else if (neg_reg)
                        res_next = (qs > 64'd2147483648) ? 64'(signed'(S32_MIN))
                                                         : 64'(-qs);
                    else
                        res_next = (qs > 64'd2147483647) ? 64'(signed'(S32_MAX)) : qs;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cnt_reg   <= cnt_next;
        a_reg     <= a_next;
        r_reg     <= r_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        d_reg     <= d_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        zsign_reg <= zsign_next;
        res_reg   <= res_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res      = res_reg;

endmodule

/* design/tds_datapath.sv */
// point window, operand selection and result register
// depends on tds_pkg and tds_arith

module tds_datapath
    import tds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tds_in_t     in_data,
    input  logic        load_in,
    input  logic [3:0]  step,
    input  logic        step_go,
    input  logic        shift_win,
    input  logic        place_new,
    input  logic        emit_go,
    input  logic [1:0]  emit_idx,
    input  logic        emit_has_next,
    input  logic        emit_end,
    input  logic [1:0]  fill,
    output tds_sts_t    ar_sts,
    output tds_out_t    emit_data
);

    logic signed [31:0] hx [WIN];
    logic signed [31:0] hy [WIN];
    logic signed [15:0] hh [WIN];
    logic signed [19:0] hv [WIN];
    logic signed [31:0] ht [WIN];
    logic        [31:0] ha [WIN];
    logic signed [31:0] hacc [WIN];
    logic signed [31:0] hk [WIN];
    logic signed [31:0] hdk [WIN];

    tds_in_t     pt_reg;
    logic [31:0] arcp_reg;
    logic [63:0] sq_reg;
    logic [63:0] sx_reg;
    logic        ovf_reg;
    logic signed [31:0] jerk_reg;

    tds_cmd_t           cmd;
    logic        [63:0] opa;
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic        [63:0] res;

    logic [1:0] last_i;
    logic [1:0] last_i1;
    logic [1:0] ni;
    logic [1:0] ni1;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [64:0] ssum;
    logic [32:0] arc_sum;
    logic signed [16:0] dh;
    logic signed [17:0] wr;
    logic signed [63:0] wnum;

    tds_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .opa   (opa),
        .num   (num),
        .den   (den),
        .sts   (ar_sts),
        .res   (res)
    );

    assign last_i  = fill - 2'd1;
    assign last_i1 = fill - 2'd2;
    assign ni      = emit_idx + 2'd1;
    assign ni1     = fill;

    assign dx = 33'(pt_reg.pos_x) - 33'(hx[last_i]);
    assign dy = 33'(pt_reg.pos_y) - 33'(hy[last_i]);
    assign ux = dx[32] ? 32'(-dx) : dx[31:0];
    assign uy = dy[32] ? 32'(-dy) : dy[31:0];
    assign ssum = {1'b0, sx_reg} + {1'b0, sq_reg};
    // rounded root can reach 2^32
    assign arc_sum = {1'b0, ha[last_i]} + res[32:0];
    assign dh = 17'(pt_reg.heading) - 17'(hh[last_i]);

    always_comb
    begin
        // wrap to [-pi, pi), the difference spans up to three periods
        wr = 18'(dh);
        for (int k = 0; k < 3; k++)
        begin
            if (wr >= 18'(PI_Q12))
                wr = wr - 18'(TWO_PI_Q12);
            else if (wr < -18'(PI_Q12))
                wr = wr + 18'(TWO_PI_Q12);
        end
    end
    assign wnum = 64'(wr) * CURV_SCALE;

    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op    = OP_DIV;
        opa       = ssum[63:0];
        num       = '0;
        den       = '0;
        if (step_go)
        begin
            unique case (step)
                S_ROOT:
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_SQRT;
                end
                S_ACC:
                begin
                    cmd.start = 1'b1;
                    num = (64'(pt_reg.speed) - 64'(hv[last_i])) * US_PER_S;
                    den = 64'(pt_reg.rel_time) - 64'(ht[last_i]);
                end
                S_CURV:
                begin
                    cmd.start = 1'b1;
                    num = wnum;
                    den = 64'({1'b0, arcp_reg}) - 64'({1'b0, ha[last_i]});
                end
                S_DK:
                begin
                    cmd.start = 1'b1;
                    num = (64'(hk[last_i]) - 64'(hk[last_i1])) * MM_PER_M;
                    den = 64'({1'b0, ha[last_i]}) - 64'({1'b0, ha[last_i1]});
                end
                S_DKEND:
                begin
                    cmd.start = 1'b1;
                    num = (64'sd0 - 64'(hk[last_i1])) * MM_PER_M;
                    den = 64'({1'b0, ha[last_i]}) - 64'({1'b0, ha[last_i1]});
                end
                S_JERK:
                begin
                    cmd.start = 1'b1;
                    num = (64'(hacc[ni]) - 64'(hacc[emit_idx])) * US_PER_S;
                    den = 64'(ht[ni]) - 64'(ht[emit_idx]);
                end
                S_CACC:
                begin
                    cmd.start = 1'b1;
                    num = (64'(hdk[ni]) - 64'(hdk[emit_idx])) * MM_PER_M;
                    den = 64'({1'b0, ha[ni]}) - 64'({1'b0, ha[emit_idx]});
                end
                default:
                begin
                    cmd.start = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            pt_reg   <= in_data;
            arcp_reg <= '0;
        end
        if (step_go && step == S_SQX)
            sx_reg <= 64'(ux) * 64'(ux);
        if (step_go && step == S_SQY)
        begin
            sq_reg  <= 64'(uy) * 64'(uy);
        end
        if (step_go && step == S_ROOT)
            ovf_reg <= ssum[64];
        if (step_go && step == S_ARC)
            arcp_reg <= ovf_reg ? 32'hFFFFFFFF
                                : (arc_sum[32] ? 32'hFFFFFFFF : arc_sum[31:0]);
        if (ar_sts.done)
        begin
            unique case (step)
                S_ACC:   hacc[last_i]  <= res[31:0];
                S_CURV:  hk[last_i]    <= res[31:0];
                S_DK:    hdk[last_i1]  <= res[31:0];
                S_DKEND: hdk[last_i1]  <= res[31:0];
                S_JERK:  jerk_reg      <= res[31:0];
                default: ;
            endcase
        end
        if (shift_win)
        begin
            hx[0] <= hx[1];   hx[1] <= hx[2];
            hy[0] <= hy[1];   hy[1] <= hy[2];
            hh[0] <= hh[1];   hh[1] <= hh[2];
            hv[0] <= hv[1];   hv[1] <= hv[2];
            ht[0] <= ht[1];   ht[1] <= ht[2];
            ha[0] <= ha[1];   ha[1] <= ha[2];
            hacc[0] <= hacc[1]; hacc[1] <= hacc[2];
            hk[0] <= hk[1];   hk[1] <= hk[2];
            hdk[0] <= hdk[1]; hdk[1] <= hdk[2];
        end
        if (place_new)
        begin
            hx[ni1]   <= pt_reg.pos_x;
            hy[ni1]   <= pt_reg.pos_y;
            hh[ni1]   <= pt_reg.heading;
            hv[ni1]   <= pt_reg.speed;
            ht[ni1]   <= pt_reg.rel_time;
            ha[ni1]   <= arcp_reg;
            hacc[ni1] <= '0;
            hk[ni1]   <= '0;
            hdk[ni1]  <= '0;
        end
        if (emit_go)
        begin
            emit_data.out_x          <= hx[emit_idx];
            emit_data.out_y          <= hy[emit_idx];
            emit_data.out_heading    <= hh[emit_idx];
            emit_data.out_speed      <= hv[emit_idx];
            emit_data.out_time       <= ht[emit_idx];
            emit_data.arc_length     <= ha[emit_idx];
            emit_data.accel          <= hacc[emit_idx];
            emit_data.jerk           <= emit_has_next ? jerk_reg : '0;
            emit_data.curvature      <= hk[emit_idx];
            emit_data.curvature_rate <= hdk[emit_idx];
            emit_data.curvature_accel <= emit_has_next ? res[31:0] : '0;
            emit_data.end_of_run     <= emit_end;
        end
    end

endmodule

/* design/tds_ctrl.sv */
// sequencer: accepts a point, runs the update steps, emits and shifts the window
// depends on tds_pkg

module tds_ctrl
    import tds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_stall,
    input  tds_sts_t   ar_sts,
    output logic       load_in,
    output logic [3:0] step,
    output logic       step_go,
    output logic       shift_win,
    output logic       place_new,
    output logic       emit_go,
    output logic [1:0] emit_idx,
    output logic       emit_has_next,
    output logic       emit_end,
    output logic [1:0] fill
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ISSUE = 4'd1;
    localparam logic [3:0] ST_WAIT  = 4'd2;
    localparam logic [3:0] ST_PLACE = 4'd3;
    localparam logic [3:0] ST_EMIT  = 4'd4;
    localparam logic [3:0] ST_OUT   = 4'd5;
    localparam logic [3:0] ST_NEXT  = 4'd6;

    logic [3:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] fill_reg, fill_next;
    logic       last_reg, last_next;
    logic [1:0] ei_reg, ei_next;
    logic       ovalid_reg, ovalid_next;
    logic       phase_reg, phase_next;
    logic       endflag_reg, endflag_next;

    logic       is_div;

    assign is_div = (step_reg == S_ROOT) || (step_reg == S_ACC) || (step_reg == S_CURV)
                 || (step_reg == S_DK) || (step_reg == S_DKEND)
                 || (step_reg == S_JERK) || (step_reg == S_CACC);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        fill_next    = fill_reg;
        last_next    = last_reg;
        ei_next      = ei_reg;
        ovalid_next  = ovalid_reg;
        phase_next   = phase_reg;
        endflag_next = endflag_reg;
        load_in      = 1'b0;
        step_go      = 1'b0;
        shift_win    = 1'b0;
        place_new    = 1'b0;
        emit_go      = 1'b0;
        emit_has_next = 1'b0;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    load_in    = 1'b1;
                    last_next  = last_in;
                    state_next = (fill_reg == 2'd0) ? ST_PLACE : ST_ISSUE;
                    step_next  = S_SQX;
                end
            end
            ST_ISSUE:
            begin
                step_go = 1'b1;
                if (is_div)
                    state_next = ST_WAIT;
                else if (step_reg == S_ARC)
                begin
                    step_next = S_ACC;
                end
                else
                    step_next = step_reg + 4'd1;
            end
            ST_WAIT:
            begin
                if (ar_sts.done)
                begin
                    state_next = ST_ISSUE;
                    unique case (step_reg)
                        S_ROOT: step_next = S_ARC;
                        S_ACC:  step_next = S_CURV;
                        S_CURV:
                        begin
                            if (fill_reg >= 2'd2)
                                step_next = S_DK;
                            else
                                state_next = ST_PLACE;
                        end
                        S_DK:   state_next = ST_PLACE;
                        S_DKEND:
                        begin
                            state_next = ST_EMIT;
                            ei_next    = '0;
                        end
                        S_JERK: step_next = S_CACC;
                        S_CACC: state_next = ST_OUT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PLACE:
            begin
                // window full: emit oldest first, then shift
                if (fill_reg == 2'd3)
                begin
                    ei_next      = '0;
                    endflag_next = 1'b0;
                    phase_next   = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    place_new = 1'b1;
                    fill_next = fill_reg + 2'd1;
                    if (last_reg)
                    begin
                        phase_next = 1'b0;
                        ei_next    = '0;
                        if (fill_reg >= 2'd1)
                        begin
                            step_next  = S_DKEND;
                            state_next = ST_ISSUE;
                        end
                        else
                            state_next = ST_EMIT;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!ovalid_reg)
                begin
                    if (phase_reg || (ei_reg + 2'd1 < fill_reg))
                    begin
                        step_next  = S_JERK;
                        state_next = ST_ISSUE;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    emit_go       = 1'b1;
                    emit_has_next = phase_reg || (ei_reg + 2'd1 < fill_reg);
                    ovalid_next   = 1'b1;
                    state_next    = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (phase_reg)
                begin
                    shift_win  = 1'b1;
                    fill_next  = 2'd2;
                    phase_next = 1'b0;
                    state_next = ST_PLACE;
                end
                else if (ei_reg + 2'd1 < fill_reg)
                begin
                    ei_next    = ei_reg + 2'd1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    fill_next  = 2'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= S_SQX;
            fill_reg    <= 2'd0;
            last_reg    <= 1'b0;
            ei_reg      <= 2'd0;
            ovalid_reg  <= 1'b0;
            phase_reg   <= 1'b0;
            endflag_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            fill_reg    <= fill_next;
            last_reg    <= last_next;
            ei_reg      <= ei_next;
            ovalid_reg  <= ovalid_next;
            phase_reg   <= phase_next;
            endflag_reg <= endflag_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign step      = step_reg;
    assign emit_idx  = ei_reg;
    assign emit_end  = !phase_reg && (ei_reg + 2'd1 == fill_reg) && !endflag_reg;
    assign fill      = fill_reg;

endmodule

/* design/trajectory_derivative_stream_unit.sv */
// top level of the trajectory derivative stream unit
// depends on tds_pkg, tds_ctrl and tds_datapath

// One shared square root and divide unit sets the time per point. The first point of a
// run needs no root or quotient; an ordinary point with a full window runs one root and
// five quotients; a final point arriving with a full window also flushes the window.
// Output stalls add to the time per point. A new point is taken only when the previous
// one's work is done; a finished result waits in the output register and the next quotient
// of the emit sequence starts only once that register has been taken.

module trajectory_derivative_stream_unit
    import tds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  tds_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output tds_out_t out_data
);

    tds_sts_t   ar_sts;
    logic       load_in;
    logic [3:0] step;
    logic       step_go;
    logic       shift_win;
    logic       place_new;
    logic       emit_go;
    logic [1:0] emit_idx;
    logic       emit_has_next;
    logic       emit_end;
    logic [1:0] fill;

    tds_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .last_in       (in_data.last_point),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ar_sts        (ar_sts),
        .load_in       (load_in),
        .step          (step),
        .step_go       (step_go),
        .shift_win     (shift_win),
        .place_new     (place_new),
        .emit_go       (emit_go),
        .emit_idx      (emit_idx),
        .emit_has_next (emit_has_next),
        .emit_end      (emit_end),
        .fill          (fill)
    );

    tds_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_data       (in_data),
        .load_in       (load_in),
        .step          (step),
        .step_go       (step_go),
        .shift_win     (shift_win),
        .place_new     (place_new),
        .emit_go       (emit_go),
        .emit_idx      (emit_idx),
        .emit_has_next (emit_has_next),
        .emit_end      (emit_end),
        .fill          (fill),
        .ar_sts        (ar_sts),
        .emit_data     (out_data)
    );

endmodule
